// ===== rtl/satl_pkg.sv =====
// shared types, constants and lfsr step for the set-associative tag lookup
package satl_pkg;

  // outcome codes carried on the result
  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_MISS     = 2'd1,
    OUT_UNCACHED = 2'd2
  } outcome_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CACHEABLE_BASE  = 3'd0,
    REG_CACHEABLE_LIMIT = 3'd1,
    REG_HIT_DELAY       = 3'd2,
    REG_MISS_DELAY      = 3'd3,
    REG_UNCACHED_DELAY  = 3'd4
  } reg_idx_t;

  // control state: clearing pass after reset, then normal running
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned FIELD_BITS    = 32;
  localparam int unsigned DELAY_BITS    = 8;
  localparam int unsigned LFSR_BITS     = 8;

  localparam logic [31:0]           RST_CACHEABLE_BASE  = 32'h0000_0000;
  localparam logic [31:0]           RST_CACHEABLE_LIMIT = 32'hFFFF_FFFF;
  localparam logic [DELAY_BITS-1:0] RST_HIT_DELAY       = 8'd1;
  localparam logic [DELAY_BITS-1:0] RST_MISS_DELAY      = 8'd20;
  localparam logic [DELAY_BITS-1:0] RST_UNCACHED_DELAY  = 8'd20;

  // xnor lfsr, taps 8,4,3,2, shifting left with the new bit at bit 0
  function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
    lfsr_step = {s[LFSR_BITS-2:0], ~(s[7] ^ s[3] ^ s[2] ^ s[1])};
  endfunction

endpackage

// ===== rtl/satl_way_ram.sv =====
// one way of the tag array: a valid bit and a tag per set, registered read
module satl_way_ram #(
  parameter int unsigned DEPTH_BITS = 6,
  parameter int unsigned WIDTH      = 22
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [DEPTH_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [DEPTH_BITS-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [2**DEPTH_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/set_assoc_tag_lookup_lfsr_replace_core.sv =====
// top level: set-associative tag lookup with xnor lfsr random replacement
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-------------------------------------
//  item in  | addr                             | taken at an edge with start & !busy
//  result   | outcome, miss, delay             | done high for one cycle, no stall
//  config   | cfg_we, cfg_index, cfg_data      | written at an edge with cfg_we high
//
//  one item per clock while busy is low; its result passes the input register, then the result register
//  the tag read is a registered memory read, so the edge that takes an item
//  also launches the read of its set; compare, fill and lfsr all sit in the
//  following cycle, and the result register captures the outcome from there
//  after reset the tag array is swept once, one set a cycle over all 2**SET_BITS
//  sets (64 at the default), with busy high; config writes are taken then
//  the receiver cannot stall, so results never back up into the input side
module set_assoc_tag_lookup_lfsr_replace_core
  import satl_pkg::*;
#(
  parameter int unsigned WAYS      = 4,
  parameter int unsigned SET_BITS  = 6,
  parameter int unsigned LINE_BITS = 5,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  // item in
  input  logic                     start,
  output logic                     busy,
  input  logic [FIELD_BITS-1:0]    addr,
  // result
  output logic                     done,
  output logic [1:0]               outcome,
  output logic                     miss,
  output logic [DELAY_BITS-1:0]    delay,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // address bits that take part; anything above the port width is zero anyway
  localparam int unsigned AW        = (ADDR_BITS < FIELD_BITS) ? ADDR_BITS : FIELD_BITS;
  localparam int unsigned TAG_LSB   = LINE_BITS + SET_BITS;
  localparam int unsigned TAG_BITS  = AW - TAG_LSB;
  localparam int unsigned WAY_BITS  = $clog2(WAYS);
  localparam int unsigned ENTRY_BITS = TAG_BITS + 1;
  localparam int unsigned LFSR_STATES = 2**LFSR_BITS;
  localparam logic [FIELD_BITS-1:0] ADDR_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - AW);

  // configuration registers
  logic [31:0]           cacheable_base;
  logic [31:0]           cacheable_limit;
  logic [DELAY_BITS-1:0] hit_delay;
  logic [DELAY_BITS-1:0] miss_delay;
  logic [DELAY_BITS-1:0] uncached_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      cacheable_base  <= RST_CACHEABLE_BASE;
      cacheable_limit <= RST_CACHEABLE_LIMIT;
      hit_delay       <= RST_HIT_DELAY;
      miss_delay      <= RST_MISS_DELAY;
      uncached_delay  <= RST_UNCACHED_DELAY;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CACHEABLE_BASE:  cacheable_base  <= cfg_data;
        REG_CACHEABLE_LIMIT: cacheable_limit <= cfg_data;
        REG_HIT_DELAY:       hit_delay       <= cfg_data[DELAY_BITS-1:0];
        REG_MISS_DELAY:      miss_delay      <= cfg_data[DELAY_BITS-1:0];
        REG_UNCACHED_DELAY:  uncached_delay  <= cfg_data[DELAY_BITS-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // control: clearing pass, then run
  state_t                state;
  state_t                state_next;
  logic [SET_BITS-1:0]   clr_idx;
  logic                  clearing;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == {SET_BITS{1'b1}}) state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  assign busy = clearing;

  logic accept;
  assign accept = start && !busy;

  // input register: the item in flight during its lookup cycle
  logic                  s_valid;
  logic [FIELD_BITS-1:0] a_q;
  logic [FIELD_BITS-1:0] a_in;

  assign a_in = addr & ADDR_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_q <= a_in;
    end
  end

  logic [SET_BITS-1:0] in_set;
  logic [SET_BITS-1:0] set_q;
  logic [TAG_BITS-1:0] tag_q;

  assign in_set = a_in[LINE_BITS +: SET_BITS];
  assign set_q  = a_q[LINE_BITS +: SET_BITS];
  assign tag_q  = a_q[TAG_LSB +: TAG_BITS];

  // tag array, one memory per way
  logic [WAYS-1:0]       way_we;
  logic [SET_BITS-1:0]   way_waddr;
  logic [ENTRY_BITS-1:0] way_wdata;
  logic [ENTRY_BITS-1:0] way_rdata [WAYS];

  for (genvar gw = 0; gw < WAYS; gw++) begin : g_way
    satl_way_ram #(
      .DEPTH_BITS (SET_BITS),
      .WIDTH      (ENTRY_BITS)
    ) u_way_ram (
      .clk   (clk),
      .we    (way_we[gw]),
      .waddr (way_waddr),
      .wdata (way_wdata),
      .re    (accept),
      .raddr (in_set),
      .rdata (way_rdata[gw])
    );
  end

  // victim way from the lfsr: state modulo WAYS as a constant table
  logic [WAY_BITS-1:0] vic_tab [LFSR_STATES];

  for (genvar gv = 0; gv < LFSR_STATES; gv++) begin : g_vic
    assign vic_tab[gv] = WAY_BITS'(gv % WAYS);
  end

  // bypass for a fill that lands on the set being read in the same edge
  logic                fwd_valid;
  logic [WAY_BITS-1:0] fwd_way;
  logic [TAG_BITS-1:0] fwd_tag;

  logic [WAYS-1:0]     eff_valid;
  logic [TAG_BITS-1:0] eff_tag [WAYS];
  logic [WAYS-1:0]     hit_vec;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (fwd_valid && fwd_way == WAY_BITS'(w)) begin
        eff_valid[w] = 1'b1;
        eff_tag[w]   = fwd_tag;
      end else begin
        eff_valid[w] = way_rdata[w][TAG_BITS];
        eff_tag[w]   = way_rdata[w][TAG_BITS-1:0];
      end
      hit_vec[w] = eff_valid[w] && (eff_tag[w] == tag_q);
    end
  end

  // lowest-numbered invalid way
  logic                found;
  logic [WAY_BITS-1:0] inv_way;

  always_comb begin
    found   = 1'b0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!eff_valid[w] && !found) begin
        found   = 1'b1;
        inv_way = WAY_BITS'(w);
      end
    end
  end

  logic                 cachable;
  logic                 hit;
  logic                 do_fill;
  logic                 lfsr_adv;
  logic [LFSR_BITS-1:0] lfsr;
  logic [LFSR_BITS-1:0] lfsr_stepped;
  logic [LFSR_BITS-1:0] lfsr_next;
  logic [WAY_BITS-1:0]  victim;

  assign cachable     = (a_q >= cacheable_base) && (a_q <= cacheable_limit);
  assign hit          = |hit_vec;
  assign do_fill      = s_valid && cachable && !hit;
  assign lfsr_adv     = do_fill && !found;
  assign lfsr_stepped = lfsr_step(lfsr);
  assign lfsr_next    = lfsr_adv ? lfsr_stepped : lfsr;
  assign victim       = found ? inv_way : vic_tab[lfsr_stepped];

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= '0;
    end else begin
      lfsr <= lfsr_next;
    end
  end

  // write port: whole row cleared during the sweep, else one way filled
  always_comb begin
    if (clearing) begin
      way_we    = {WAYS{1'b1}};
      way_waddr = clr_idx;
      way_wdata = '0;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        way_we[w] = do_fill && (victim == WAY_BITS'(w));
      end
      way_waddr = set_q;
      way_wdata = {1'b1, tag_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= do_fill && accept && (in_set == set_q);
    end
  end

  always_ff @(posedge clk) begin
    fwd_way <= victim;
    fwd_tag <= tag_q;
  end

  // result register
  outcome_t              res_outcome;
  logic [DELAY_BITS-1:0] res_delay;

  always_comb begin
    if (!cachable) begin
      res_outcome = OUT_UNCACHED;
      res_delay   = uncached_delay;
    end else if (hit) begin
      res_outcome = OUT_HIT;
      res_delay   = hit_delay;
    end else begin
      res_outcome = OUT_MISS;
      res_delay   = miss_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      outcome <= res_outcome;
      miss    <= (res_outcome != OUT_HIT);
      delay   <= res_delay;
    end
  end

endmodule

// ===== rtl/satl_checker.sv =====
// port-level checks for the tag lookup core, bound to the top level
module satl_checker
  import satl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic [1:0]            outcome,
  input logic                  miss
);

  // every taken item gives a result strobe, after the input and result registers
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("item taken without a result two edges later");

  // no result without an item taken behind it, through the input and result registers
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result with no item behind it");

  // miss flag follows the outcome code
  a_miss_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (miss == (outcome != OUT_HIT)))
    else $error("miss flag disagrees with outcome");

  // once the clearing sweep ends, busy never returns until reset
  a_busy_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy raised again after the sweep");

endmodule

bind set_assoc_tag_lookup_lfsr_replace_core satl_checker u_satl_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .outcome (outcome),
  .miss    (miss)
);
